[rtl/core/xenc_pkg.sv]
package xenc_pkg;

  // result buffer geometry
  localparam int MAX_BYTES = 12;
  localparam int BYTE_VEC_W = 8 * MAX_BYTES;
  localparam int CNT_W = 4;

  // mnemonics
  localparam logic [2:0] KIND_CALL = 3'd0;
  localparam logic [2:0] KIND_MOV  = 3'd1;
  localparam logic [2:0] KIND_NOP  = 3'd2;
  localparam logic [2:0] KIND_POP  = 3'd3;
  localparam logic [2:0] KIND_PUSH = 3'd4;
  localparam logic [2:0] KIND_RET  = 3'd5;
  localparam logic [2:0] KIND_SUB  = 3'd6;

  // operand classes
  localparam logic [1:0] CLS_REG = 2'd0;
  localparam logic [1:0] CLS_MEM = 2'd1;
  localparam logic [1:0] CLS_IMM = 2'd2;
  localparam logic [1:0] CLS_SYM = 2'd3;

  // operand sizes
  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  localparam logic [4:0] BASE_RIP = 5'd16;

  // prefixes
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] REX_BASE   = 8'h40;
  localparam logic [7:0] REX_W      = 8'h48;
  localparam logic [7:0] REX_R_BIT  = 8'h04;
  localparam logic [7:0] REX_B_BIT  = 8'h01;

  // opcodes
  localparam logic [7:0] OP_MOV_RM8      = 8'h88;
  localparam logic [7:0] OP_MOV_RM       = 8'h89;
  localparam logic [7:0] OP_MOV_R8_RM    = 8'h8a;
  localparam logic [7:0] OP_MOV_R_RM     = 8'h8b;
  localparam logic [7:0] OP_MOV_RM8_IMM  = 8'hc6;
  localparam logic [7:0] OP_MOV_RM_IMM   = 8'hc7;
  localparam logic [7:0] OP_MOV_R8_IMM   = 8'hb0;
  localparam logic [7:0] OP_MOV_R_IMM    = 8'hb8;
  localparam logic [7:0] OP_SUB_RM8      = 8'h28;
  localparam logic [7:0] OP_SUB_RM       = 8'h29;
  localparam logic [7:0] OP_SUB_AL_IMM   = 8'h2c;
  localparam logic [7:0] OP_SUB_AX_IMM   = 8'h2d;
  localparam logic [7:0] OP_GRP1_RM8_IMM = 8'h80;
  localparam logic [7:0] OP_GRP1_RM_IMM  = 8'h81;
  localparam logic [7:0] OP_GRP1_RM_IMM8 = 8'h83;
  localparam logic [7:0] OP_CALL_REL     = 8'he8;
  localparam logic [7:0] OP_RET          = 8'hc3;
  localparam logic [7:0] OP_NOP          = 8'h90;
  localparam logic [7:0] OP_PUSH_R       = 8'h50;
  localparam logic [7:0] OP_POP_R        = 8'h58;

  // modrm pieces
  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [2:0] EXT_MOV    = 3'd0;
  localparam logic [2:0] EXT_SUB    = 3'd5;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_RIP     = 3'd5;

  // one decoded instruction request
  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         dst_class;
    logic [1:0]         dst_size;
    logic [4:0]         dst_reg;
    logic [1:0]         src_class;
    logic [1:0]         src_size;
    logic [4:0]         src_reg;
    logic signed [31:0] mem_disp;
    logic [31:0]        imm_value;
  } instr_t;

  // encoded bytes, first byte in the low octet
  typedef struct packed {
    logic [BYTE_VEC_W-1:0] bytes;
    logic [CNT_W-1:0]      count;
    logic                  empty;
  } enc_res_t;

  // immediate bytes at operand size, capped at four
  function automatic logic [2:0] imm_bytes(input logic [1:0] size);
    logic [2:0] n;
    case (size)
      SZ_8:    n = 3'd1;
      SZ_16:   n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/xenc_encode.sv]
module xenc_encode import xenc_pkg::*; (
  input  instr_t   instr,
  output enc_res_t res
);

  // rex bits contributed by a register operand
  function automatic logic [7:0] rex_reg(input logic [3:0] reg_n, input logic [1:0] size,
                                         input logic is_r);
    logic [7:0] p;
    p = 8'h00;
    if (size == SZ_8 && reg_n inside {[4'd4:4'd7]}) p = p | REX_BASE;
    if (size == SZ_64) p = p | REX_W;
    if (reg_n[3]) p = p | REX_BASE | (is_r ? REX_R_BIT : REX_B_BIT);
    return p;
  endfunction

  // rex bits contributed by a memory operand
  function automatic logic [7:0] rex_mem(input logic [4:0] base, input logic [1:0] size);
    logic [7:0] p;
    p = 8'h00;
    if (size == SZ_64) p = p | REX_W;
    if (!base[4] && base[3]) p = p | REX_BASE | REX_B_BIT;
    return p;
  endfunction

  function automatic logic mem_ok(input logic [4:0] base);
    return (base == BASE_RIP) || (!base[4] && base[2:0] != RM_SIB);
  endfunction

  logic [4:0]  mem_base;
  logic [1:0]  mem_mod;
  logic [2:0]  mem_rm;
  logic [2:0]  mem_dlen;
  logic [31:0] mem_dval;
  logic        fits8;

  logic        ok;
  logic        is_sub;
  logic        has_pfx;
  logic [7:0]  rex;
  logic [7:0]  opc;
  logic        has_modrm;
  logic [7:0]  modrm;
  logic [2:0]  disp_len;
  logic [31:0] disp_v;
  logic [2:0]  imm_len;
  logic [31:0] imm_v;

  // memory operand addressing: mod, rm and displacement
  always_comb begin
    mem_base = (instr.dst_class == CLS_MEM) ? instr.dst_reg : instr.src_reg;
    fits8 = (instr.mem_disp[31:7] == 25'h0) || (instr.mem_disp[31:7] == 25'h1ffffff);
    mem_rm = mem_base[2:0];
    mem_dval = instr.mem_disp;
    if (mem_base == BASE_RIP) begin
      mem_mod = MOD_NODISP;
      mem_rm = RM_RIP;
      mem_dlen = 3'd4;
      mem_dval = 32'h0;
    end else if (instr.mem_disp == 32'sd0 && mem_base[2:0] != RM_RIP) begin
      mem_mod = MOD_NODISP;
      mem_dlen = 3'd0;
    end else if (fits8) begin
      mem_mod = MOD_DISP8;
      mem_dlen = 3'd1;
    end else begin
      mem_mod = MOD_DISP32;
      mem_dlen = 3'd4;
    end
  end

  // instruction form selection
  always_comb begin
    ok = 1'b0;
    is_sub = (instr.kind == KIND_SUB);
    has_pfx = 1'b0;
    rex = 8'h00;
    opc = 8'h00;
    has_modrm = 1'b0;
    modrm = 8'h00;
    disp_len = 3'd0;
    disp_v = 32'h0;
    imm_len = 3'd0;
    imm_v = instr.imm_value;
    case (instr.kind)
      KIND_CALL: begin
        ok = (instr.dst_class == CLS_SYM);
        opc = OP_CALL_REL;
        imm_len = 3'd4;
        imm_v = 32'h0;
      end
      KIND_NOP: begin
        ok = 1'b1;
        opc = OP_NOP;
      end
      KIND_RET: begin
        ok = 1'b1;
        opc = OP_RET;
      end
      KIND_POP, KIND_PUSH: begin
        ok = (instr.dst_class == CLS_REG) && (instr.dst_size == SZ_64) && !instr.dst_reg[4];
        rex = instr.dst_reg[3] ? (REX_BASE | REX_B_BIT) : 8'h00;
        opc = ((instr.kind == KIND_POP) ? OP_POP_R : OP_PUSH_R) | {5'd0, instr.dst_reg[2:0]};
      end
      KIND_MOV, KIND_SUB: begin
        has_pfx = (instr.dst_size == SZ_16);
        if (instr.dst_class == CLS_REG && instr.src_class == CLS_REG) begin
          // register to register
          ok = !instr.dst_reg[4] && !instr.src_reg[4] && (instr.dst_size == instr.src_size);
          rex = rex_reg(instr.src_reg[3:0], instr.src_size, 1'b1)
              | rex_reg(instr.dst_reg[3:0], instr.dst_size, 1'b0);
          if (is_sub) opc = (instr.dst_size == SZ_8) ? OP_SUB_RM8 : OP_SUB_RM;
          else opc = (instr.dst_size == SZ_8) ? OP_MOV_RM8 : OP_MOV_RM;
          has_modrm = 1'b1;
          modrm = {MOD_REG, instr.src_reg[2:0], instr.dst_reg[2:0]};
        end else if (!is_sub && instr.dst_class == CLS_REG && instr.src_class == CLS_MEM) begin
          // load from memory
          ok = !instr.dst_reg[4] && mem_ok(instr.src_reg) && (instr.dst_size == instr.src_size);
          rex = rex_reg(instr.dst_reg[3:0], instr.dst_size, 1'b1)
              | rex_mem(instr.src_reg, instr.src_size);
          opc = (instr.dst_size == SZ_8) ? OP_MOV_R8_RM : OP_MOV_R_RM;
          has_modrm = 1'b1;
          modrm = {mem_mod, instr.dst_reg[2:0], mem_rm};
          disp_len = mem_dlen;
          disp_v = mem_dval;
        end else if (instr.dst_class == CLS_REG && instr.src_class == CLS_IMM) begin
          // immediate to register
          ok = !instr.dst_reg[4] && (instr.src_size <= SZ_32) && (instr.src_size <= instr.dst_size);
          if (!is_sub && instr.dst_size == SZ_64) begin
            has_pfx = 1'b0;
            rex = REX_W | {7'd0, instr.dst_reg[3]};
            opc = OP_MOV_RM_IMM;
            has_modrm = 1'b1;
            modrm = {MOD_REG, EXT_MOV, instr.dst_reg[2:0]};
            imm_len = 3'd4;
          end else begin
            rex = rex_reg(instr.dst_reg[3:0], instr.dst_size, 1'b0);
            if (!is_sub) begin
              opc = ((instr.dst_size == SZ_8) ? OP_MOV_R8_IMM : OP_MOV_R_IMM)
                  | {5'd0, instr.dst_reg[2:0]};
              imm_len = imm_bytes(instr.dst_size);
            end else if (instr.dst_reg == 5'd0 && (instr.dst_size == instr.src_size ||
                         (instr.dst_size == SZ_64 && instr.src_size == SZ_32))) begin
              opc = (instr.dst_size == SZ_8) ? OP_SUB_AL_IMM : OP_SUB_AX_IMM;
              imm_len = imm_bytes(instr.dst_size);
            end else begin
              opc = (instr.dst_size == SZ_8) ? OP_GRP1_RM8_IMM :
                    ((instr.src_size == SZ_8) ? OP_GRP1_RM_IMM8 : OP_GRP1_RM_IMM);
              has_modrm = 1'b1;
              modrm = {MOD_REG, EXT_SUB, instr.dst_reg[2:0]};
              imm_len = (instr.dst_size == SZ_8 || instr.src_size == SZ_8) ? 3'd1 :
                        imm_bytes(instr.dst_size);
            end
          end
        end else if (instr.dst_class == CLS_MEM && instr.src_class == CLS_IMM) begin
          // immediate to memory
          ok = mem_ok(instr.dst_reg) && (instr.src_size <= SZ_32) &&
               (instr.src_size <= instr.dst_size);
          rex = rex_mem(instr.dst_reg, instr.dst_size);
          has_modrm = 1'b1;
          disp_len = mem_dlen;
          disp_v = mem_dval;
          if (is_sub) begin
            opc = (instr.dst_size == SZ_8) ? OP_GRP1_RM8_IMM :
                  ((instr.src_size == SZ_8) ? OP_GRP1_RM_IMM8 : OP_GRP1_RM_IMM);
            modrm = {mem_mod, EXT_SUB, mem_rm};
            imm_len = (instr.dst_size == SZ_8 || instr.src_size == SZ_8) ? 3'd1 :
                      imm_bytes(instr.dst_size);
          end else begin
            opc = (instr.dst_size == SZ_8) ? OP_MOV_RM8_IMM : OP_MOV_RM_IMM;
            modrm = {mem_mod, EXT_MOV, mem_rm};
            imm_len = imm_bytes(instr.dst_size);
          end
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  logic [BYTE_VEC_W-1:0] acc;
  logic [BYTE_VEC_W-1:0] imm_seg;
  logic [BYTE_VEC_W-1:0] disp_seg;
  logic                  has_rex;

  // pack segments back to front, first byte ends up lowest
  always_comb begin
    has_rex = (rex != 8'h00);
    case (imm_len)
      3'd1:    imm_seg = BYTE_VEC_W'(imm_v[7:0]);
      3'd2:    imm_seg = BYTE_VEC_W'(imm_v[15:0]);
      3'd4:    imm_seg = BYTE_VEC_W'(imm_v);
      default: imm_seg = '0;
    endcase
    case (disp_len)
      3'd1:    disp_seg = BYTE_VEC_W'(disp_v[7:0]);
      3'd4:    disp_seg = BYTE_VEC_W'(disp_v);
      default: disp_seg = '0;
    endcase
    acc = imm_seg;
    acc = (acc << {disp_len, 3'b000}) | disp_seg;
    if (has_modrm) acc = (acc << 8) | BYTE_VEC_W'(modrm);
    acc = (acc << 8) | BYTE_VEC_W'(opc);
    if (has_rex) acc = (acc << 8) | BYTE_VEC_W'(rex);
    if (has_pfx) acc = (acc << 8) | BYTE_VEC_W'(PFX_OPSIZE);

    if (ok) begin
      res.bytes = acc;
      res.count = CNT_W'(has_pfx) + CNT_W'(has_rex) + CNT_W'(1) + CNT_W'(has_modrm)
                + CNT_W'(disp_len) + CNT_W'(imm_len);
      res.empty = 1'b0;
    end else begin
      res.bytes = '0;
      res.count = CNT_W'(1);
      res.empty = 1'b1;
    end
  end

endmodule

[rtl/core/xenc_serializer.sv]
module xenc_serializer import xenc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load_valid,
  input  enc_res_t enc,
  output logic     load_ready,
  output logic     out_strobe,
  output logic [7:0] out_byte,
  output logic     out_last,
  output logic     out_empty_res
);

  logic [BYTE_VEC_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  empty_r, empty_nxt;
  logic                  strobe_r, strobe_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic                  empty_out_r, empty_out_nxt;
  logic                  load;

  // buffer takes a new request when empty or on its final byte
  assign load_ready = (cnt_r == CNT_W'(0)) || (cnt_r == CNT_W'(1));
  assign load = load_valid && load_ready;

  // shift one byte out per cycle into the output register
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    empty_nxt = empty_r;
    strobe_nxt = 1'b0;
    byte_nxt = byte_r;
    last_nxt = last_r;
    empty_out_nxt = empty_out_r;
    if (cnt_r != CNT_W'(0)) begin
      strobe_nxt = 1'b1;
      byte_nxt = buf_r[7:0];
      last_nxt = (cnt_r == CNT_W'(1));
      empty_out_nxt = empty_r;
      buf_nxt = buf_r >> 8;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (load) begin
      buf_nxt = enc.bytes;
      cnt_nxt = enc.count;
      empty_nxt = enc.empty;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    empty_r <= empty_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    empty_out_r <= empty_out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_byte = byte_r;
  assign out_last = last_r;
  assign out_empty_res = empty_out_r;

endmodule

[rtl/core/x86_64_instruction_encoder_top.sv]
// channel   | ports                                    | handshake
// ----------+------------------------------------------+------------------------------
// request   | in_kind .. in_imm_value                  | start high, busy low at edge
// result    | out_byte, out_last, out_empty_res        | out_strobe, one cycle, no stall
//
// A request yields one machine byte per cycle, 1 to 12 bytes, set by the single-byte
// output register; requests follow back to back with no gap between bytes.
// After the edge that takes it, a request passes the byte buffer, then the output register.
// Reset clears the input valid flag, the byte counter and the strobe.
// busy rises only while the input register holds a request that the byte
// buffer cannot yet take; the receiver cannot stall.
module x86_64_instruction_encoder_top import xenc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [1:0]  in_dst_class,
  input  logic [1:0]  in_dst_size,
  input  logic [4:0]  in_dst_reg,
  input  logic [1:0]  in_src_class,
  input  logic [1:0]  in_src_size,
  input  logic [4:0]  in_src_reg,
  input  logic signed [31:0] in_mem_disp,
  input  logic [31:0] in_imm_value,
  output logic        out_strobe,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_empty_res
);

  logic     in_valid_r, in_valid_nxt;
  instr_t   instr_r, instr_nxt;
  logic     accept;
  logic     ser_ready;
  enc_res_t enc;

  // input register
  assign busy = in_valid_r && !ser_ready;
  assign accept = start && !busy;

  always_comb begin
    in_valid_nxt = in_valid_r;
    instr_nxt = instr_r;
    if (in_valid_r && ser_ready) in_valid_nxt = 1'b0;
    if (accept) begin
      in_valid_nxt = 1'b1;
      instr_nxt.kind = in_kind;
      instr_nxt.dst_class = in_dst_class;
      instr_nxt.dst_size = in_dst_size;
      instr_nxt.dst_reg = in_dst_reg;
      instr_nxt.src_class = in_src_class;
      instr_nxt.src_size = in_src_size;
      instr_nxt.src_reg = in_src_reg;
      instr_nxt.mem_disp = in_mem_disp;
      instr_nxt.imm_value = in_imm_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    instr_r <= instr_nxt;
  end

  // byte generation
  xenc_encode u_encode (
    .instr (instr_r),
    .res   (enc)
  );

  // byte buffer and output register
  xenc_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_valid    (in_valid_r),
    .enc           (enc),
    .load_ready    (ser_ready),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

  // bytes of one instruction come out without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside an instruction's byte stream");

  // an unsupported form is a single zero byte
  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_empty_res |-> out_last && out_byte == 8'h00)
    else $error("empty result not a single zero byte");

  // a request moved into the buffer yields a byte from the output register
  a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && ser_ready |-> ##2 out_strobe)
    else $error("loaded request produced no byte");

  // busy only with a held request
  a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_valid_r)
    else $error("busy without a held request");

endmodule

[tb/sv/x86_64_instruction_encoder_top_tb.sv]
`timescale 1ns / 100ps

module x86_64_instruction_encoder_top_tb;
  import xenc_pkg::*;

  // mnemonic code outside the defined set
  localparam logic [2:0] KIND_UNDEF = 3'd7;
  localparam int RANDOM_REQS = 333;
  localparam int REPORT_CAP = 100;

  typedef struct {
    instr_t req;
    bit     drain;
  } pending_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       empty;
  } code_byte_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  instr_t cur_req = '0;
  logic   busy;
  logic   out_strobe;
  logic [7:0] out_byte;
  logic   out_last;
  logic   out_empty_res;

  pending_t   pending_reqs[$];
  pending_t   drv_item;
  code_byte_t expected_codes[$];
  code_byte_t exp_code;
  logic [7:0] code_buf[$];

  bit req_taken = 1'b0;
  int sent_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int unsupported_cnt = 0;
  int fail_cnt = 0;

  x86_64_instruction_encoder_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (cur_req.kind),
    .in_dst_class (cur_req.dst_class),
    .in_dst_size  (cur_req.dst_size),
    .in_dst_reg   (cur_req.dst_reg),
    .in_src_class (cur_req.src_class),
    .in_src_size  (cur_req.src_size),
    .in_src_reg   (cur_req.src_reg),
    .in_mem_disp  (cur_req.mem_disp),
    .in_imm_value (cur_req.imm_value),
    .out_strobe   (out_strobe),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_empty_res(out_empty_res)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // encoding predictor
  // ---------------------------------------------------------------------------

  function automatic void emit(logic [7:0] b);
    if (code_buf.size() < MAX_BYTES) code_buf.push_back(b);
  endfunction

  // little-endian, never more than four bytes
  function automatic void emit_le(logic [31:0] v, int n);
    int i;
    for (i = 0; i < n && i < 4; i++) emit(v[8*i +: 8]);
  endfunction

  function automatic logic [7:0] rex_for_reg(logic [4:0] rnum, logic [1:0] size,
                                             logic [7:0] ext_bit);
    logic [7:0] p;
    p = 8'h00;
    // spl/bpl/sil/dil need a bare rex
    if (size == SZ_8 && rnum >= 5'd4 && rnum <= 5'd7) p |= REX_BASE;
    if (size == SZ_64) p |= REX_W;
    if (rnum[3]) p |= REX_BASE | ext_bit;
    return p;
  endfunction

  function automatic logic [7:0] rex_for_mem(logic [4:0] base, logic [1:0] size);
    logic [7:0] p;
    p = 8'h00;
    if (size == SZ_64) p |= REX_W;
    if (base < BASE_RIP && base[3]) p |= REX_BASE | REX_B_BIT;
    return p;
  endfunction

  // rsp/r12 would need a sib byte
  function automatic bit base_usable(logic [4:0] base);
    return base == BASE_RIP || (base < BASE_RIP && base[2:0] != RM_SIB);
  endfunction

  function automatic void emit_mem(logic [2:0] rf, logic [4:0] base, logic [31:0] disp);
    bit fits8;
    fits8 = disp <= 32'h0000_007f || disp >= 32'hffff_ff80;
    if (base == BASE_RIP) begin
      emit({MOD_NODISP, rf, RM_RIP});
      emit_le(32'h0, 4);
    end else if (disp == 32'h0 && base[2:0] != RM_RIP) begin
      emit({MOD_NODISP, rf, base[2:0]});
    end else if (fits8) begin
      // also rbp/r13 with zero offset, since mod 00 there means rip
      emit({MOD_DISP8, rf, base[2:0]});
      emit_le(disp, 1);
    end else begin
      emit({MOD_DISP32, rf, base[2:0]});
      emit_le(disp, 4);
    end
  endfunction

  function automatic int capped_len(logic [1:0] size);
    return (size == SZ_8) ? 1 : (size == SZ_16) ? 2 : 4;
  endfunction

  function automatic logic [7:0] grp1_opcode(logic [1:0] ds, logic [1:0] ss);
    if (ds == SZ_8) return OP_GRP1_RM8_IMM;
    return (ss == SZ_8) ? OP_GRP1_RM_IMM8 : OP_GRP1_RM_IMM;
  endfunction

  function automatic int grp1_len(logic [1:0] ds, logic [1:0] ss);
    return (ds == SZ_8 || ss == SZ_8) ? 1 : capped_len(ds);
  endfunction

  // mov and sub with two operands
  function automatic bit encode_binary(bit is_sub, instr_t r);
    logic [7:0] p;
    if (r.dst_class == CLS_REG && r.src_class == CLS_REG) begin
      if (r.dst_reg > 5'd15 || r.src_reg > 5'd15 || r.dst_size != r.src_size) return 1'b0;
      if (r.dst_size == SZ_16) emit(PFX_OPSIZE);
      p = rex_for_reg(r.src_reg, r.src_size, REX_R_BIT) |
          rex_for_reg(r.dst_reg, r.dst_size, REX_B_BIT);
      if (p != 8'h00) emit(p);
      if (is_sub) emit(r.dst_size == SZ_8 ? OP_SUB_RM8 : OP_SUB_RM);
      else emit(r.dst_size == SZ_8 ? OP_MOV_RM8 : OP_MOV_RM);
      emit({MOD_REG, r.src_reg[2:0], r.dst_reg[2:0]});
      return 1'b1;
    end
    if (!is_sub && r.dst_class == CLS_REG && r.src_class == CLS_MEM) begin
      if (r.dst_reg > 5'd15 || !base_usable(r.src_reg) || r.dst_size != r.src_size)
        return 1'b0;
      if (r.dst_size == SZ_16) emit(PFX_OPSIZE);
      p = rex_for_reg(r.dst_reg, r.dst_size, REX_R_BIT) | rex_for_mem(r.src_reg, r.src_size);
      if (p != 8'h00) emit(p);
      emit(r.dst_size == SZ_8 ? OP_MOV_R8_RM : OP_MOV_R_RM);
      emit_mem(r.dst_reg[2:0], r.src_reg, r.mem_disp);
      return 1'b1;
    end
    if (r.dst_class == CLS_REG && r.src_class == CLS_IMM) begin
      if (r.dst_reg > 5'd15 || r.src_size > SZ_32 || r.src_size > r.dst_size) return 1'b0;
      // mov r64, imm32 goes through c7 /0
      if (!is_sub && r.dst_size == SZ_64) begin
        emit(REX_W | {7'b0, r.dst_reg[3]});
        emit(OP_MOV_RM_IMM);
        emit({MOD_REG, EXT_MOV, r.dst_reg[2:0]});
        emit_le(r.imm_value, 4);
        return 1'b1;
      end
      if (r.dst_size == SZ_16) emit(PFX_OPSIZE);
      p = rex_for_reg(r.dst_reg, r.dst_size, REX_B_BIT);
      if (p != 8'h00) emit(p);
      if (!is_sub) begin
        emit((r.dst_size == SZ_8 ? OP_MOV_R8_IMM : OP_MOV_R_IMM) + r.dst_reg[2:0]);
        emit_le(r.imm_value, 1 << r.dst_size);
      end else if (r.dst_reg == 5'd0 && (r.dst_size == r.src_size ||
                   (r.dst_size == SZ_64 && r.src_size == SZ_32))) begin
        // accumulator short form
        emit(r.dst_size == SZ_8 ? OP_SUB_AL_IMM : OP_SUB_AX_IMM);
        emit_le(r.imm_value, capped_len(r.dst_size));
      end else begin
        emit(grp1_opcode(r.dst_size, r.src_size));
        emit({MOD_REG, EXT_SUB, r.dst_reg[2:0]});
        emit_le(r.imm_value, grp1_len(r.dst_size, r.src_size));
      end
      return 1'b1;
    end
    if (r.dst_class == CLS_MEM && r.src_class == CLS_IMM) begin
      if (!base_usable(r.dst_reg) || r.src_size > SZ_32 || r.src_size > r.dst_size)
        return 1'b0;
      if (r.dst_size == SZ_16) emit(PFX_OPSIZE);
      p = rex_for_mem(r.dst_reg, r.dst_size);
      if (p != 8'h00) emit(p);
      if (is_sub) begin
        emit(grp1_opcode(r.dst_size, r.src_size));
        emit_mem(EXT_SUB, r.dst_reg, r.mem_disp);
        emit_le(r.imm_value, grp1_len(r.dst_size, r.src_size));
      end else begin
        emit(r.dst_size == SZ_8 ? OP_MOV_RM8_IMM : OP_MOV_RM_IMM);
        emit_mem(EXT_MOV, r.dst_reg, r.mem_disp);
        emit_le(r.imm_value, capped_len(r.dst_size));
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit encode_instr(instr_t r);
    case (r.kind)
      KIND_CALL: begin
        if (r.dst_class != CLS_SYM) return 1'b0;
        // rel32 left as zero for later patching
        emit(OP_CALL_REL);
        emit_le(32'h0, 4);
        return 1'b1;
      end
      KIND_NOP: begin
        emit(OP_NOP);
        return 1'b1;
      end
      KIND_RET: begin
        emit(OP_RET);
        return 1'b1;
      end
      KIND_POP, KIND_PUSH: begin
        if (r.dst_class != CLS_REG || r.dst_size != SZ_64 || r.dst_reg > 5'd15) return 1'b0;
        if (r.dst_reg[3]) emit(REX_BASE | REX_B_BIT);
        emit((r.kind == KIND_POP ? OP_POP_R : OP_PUSH_R) + r.dst_reg[2:0]);
        return 1'b1;
      end
      KIND_MOV: return encode_binary(1'b0, r);
      KIND_SUB: return encode_binary(1'b1, r);
      default: return 1'b0;
    endcase
  endfunction

  // expected bytes of one accepted request
  function automatic void predict_encoding(instr_t r);
    bit ok;
    int k;
    code_buf.delete();
    ok = encode_instr(r);
    if (!ok || code_buf.size() == 0) begin
      expected_codes.push_back('{8'h00, 1'b1, 1'b1});
      unsupported_cnt++;
    end else begin
      for (k = 0; k < code_buf.size(); k++)
        expected_codes.push_back('{code_buf[k], k == code_buf.size() - 1, 1'b0});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------

  function automatic instr_t mk_req(logic [2:0] kind, logic [1:0] dc, logic [1:0] ds,
                                    logic [4:0] dr, logic [1:0] sc, logic [1:0] ss,
                                    logic [4:0] sr, logic signed [31:0] disp,
                                    logic [31:0] imm);
    instr_t r;
    r.kind = kind;
    r.dst_class = dc;
    r.dst_size = ds;
    r.dst_reg = dr;
    r.src_class = sc;
    r.src_size = ss;
    r.src_reg = sr;
    r.mem_disp = disp;
    r.imm_value = imm;
    return r;
  endfunction

  function automatic void queue_req(instr_t r, bit drain);
    pending_t e;
    e.req = r;
    e.drain = drain;
    pending_reqs.push_back(e);
  endfunction

  // register with a bias toward the accumulator
  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(0, 15));
  endfunction

  // base with a bias toward rip, rsp/r12 and rbp/r13
  function automatic logic [4:0] rand_base();
    case ($urandom_range(0, 9))
      0: return BASE_RIP;
      1: return ($urandom_range(0, 1) != 0) ? 5'd4 : 5'd12;
      2: return ($urandom_range(0, 1) != 0) ? 5'd5 : 5'd13;
      default: return 5'($urandom_range(0, 15));
    endcase
  endfunction

  // displacement spread over the three encodings and their borders
  function automatic logic signed [31:0] rand_disp();
    case ($urandom_range(0, 5))
      0: return 32'sd0;
      1: return $urandom_range(0, 255) - 128;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sd127;
          1: return -32'sd128;
          2: return 32'sd128;
          default: return -32'sd129;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_noise();
    instr_t r;
    r.kind = 3'($urandom_range(0, 7));
    r.dst_class = 2'($urandom_range(0, 3));
    r.dst_size = 2'($urandom_range(0, 3));
    r.dst_reg = 5'($urandom_range(0, 31));
    r.src_class = 2'($urandom_range(0, 3));
    r.src_size = 2'($urandom_range(0, 3));
    r.src_reg = 5'($urandom_range(0, 31));
    r.mem_disp = $urandom;
    r.imm_value = $urandom;
    return r;
  endfunction

  // supported shapes with random content
  function automatic instr_t rand_wellformed();
    instr_t r;
    r = rand_noise();
    r.kind = 3'($urandom_range(0, 6));
    r.mem_disp = rand_disp();
    case (r.kind)
      KIND_CALL: r.dst_class = CLS_SYM;
      KIND_POP, KIND_PUSH: begin
        r.dst_class = CLS_REG;
        r.dst_size = SZ_64;
        r.dst_reg = 5'($urandom_range(0, 15));
      end
      KIND_MOV, KIND_SUB: begin
        r.dst_size = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: begin
            r.dst_class = CLS_REG;
            r.src_class = CLS_REG;
            r.src_size = r.dst_size;
            r.dst_reg = rand_reg();
            r.src_reg = rand_reg();
          end
          1: begin
            r.dst_class = CLS_REG;
            r.src_class = CLS_MEM;
            r.src_size = r.dst_size;
            r.dst_reg = rand_reg();
            r.src_reg = rand_base();
          end
          2: begin
            r.dst_class = CLS_REG;
            r.src_class = CLS_IMM;
            r.src_size = 2'($urandom_range(0, (r.dst_size > SZ_32) ? 2 : r.dst_size));
            r.dst_reg = rand_reg();
          end
          default: begin
            r.dst_class = CLS_MEM;
            r.src_class = CLS_IMM;
            r.src_size = 2'($urandom_range(0, (r.dst_size > SZ_32) ? 2 : r.dst_size));
            r.dst_reg = rand_base();
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // one long stretch of back-to-back requests
  wire quiet_stretch = sent_cnt >= 180 && sent_cnt < 260;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (pending_reqs[0].drain && expected_codes.size() != 0) begin
        // hold off until the encoder has flushed everything
        start <= 1'b0;
      end else if (!quiet_stretch && $urandom_range(0, 99) < 19) begin
        start <= 1'b0;
      end else begin
        drv_item = pending_reqs.pop_front();
        cur_req <= drv_item.req;
        start <= 1'b1;
        sent_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and request capture
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_codes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_CAP)
          $display("%0t: unexpected result, expected none actual byte %h last %b empty %b",
                   $time, out_byte, out_last, out_empty_res);
      end else begin
        exp_code = expected_codes.pop_front();
        checked_cnt++;
        if (out_byte !== exp_code.val) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_CAP)
            $display("%0t: out_byte mismatch, expected %h actual %h",
                     $time, exp_code.val, out_byte);
        end
        if (out_last !== exp_code.last) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_CAP)
            $display("%0t: out_last mismatch, expected %b actual %b",
                     $time, exp_code.last, out_last);
        end
        if (out_empty_res !== exp_code.empty) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_CAP)
            $display("%0t: out_empty_res mismatch, expected %b actual %b",
                     $time, exp_code.empty, out_empty_res);
        end
      end
    end
    // request taken at this edge
    if (rst_n && start && !busy) begin
      predict_encoding(cur_req);
      req_taken = 1'b1;
      accepted_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int i;

    // directed requests
    queue_req(mk_req(KIND_CALL, CLS_SYM, SZ_64, 5'd0, CLS_REG, SZ_8, 5'd0, 0, 32'h0), 1'b0);
    queue_req(mk_req(KIND_NOP, CLS_SYM, SZ_64, 5'd31, CLS_SYM, SZ_64, 5'd31, -1,
                     32'hffff_ffff), 1'b0);
    queue_req(mk_req(KIND_RET, CLS_MEM, SZ_8, 5'd16, CLS_IMM, SZ_8, 5'd0, 0, 32'h0), 1'b0);
    queue_req(mk_req(KIND_PUSH, CLS_REG, SZ_64, 5'd15, CLS_REG, SZ_8, 5'd0, 0, 32'h0), 1'b0);
    queue_req(mk_req(KIND_POP, CLS_REG, SZ_64, 5'd0, CLS_REG, SZ_8, 5'd0, 0, 32'h0), 1'b0);
    // register number above 15
    queue_req(mk_req(KIND_PUSH, CLS_REG, SZ_64, 5'd16, CLS_REG, SZ_8, 5'd0, 0, 32'h0), 1'b0);
    // r8b <- sil forces rex
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_8, 5'd8, CLS_REG, SZ_8, 5'd6, 0, 32'h0), 1'b0);
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_16, 5'd3, CLS_REG, SZ_16, 5'd11, 0, 32'h0), 1'b0);
    queue_req(mk_req(KIND_SUB, CLS_REG, SZ_64, 5'd15, CLS_REG, SZ_64, 5'd15, 0, 32'h0), 1'b0);
    // rip base ignores the displacement
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_64, 5'd2, CLS_MEM, SZ_64, BASE_RIP, 32'h1234_5678,
                     32'h0), 1'b0);
    // rbp base with zero offset
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_32, 5'd0, CLS_MEM, SZ_32, 5'd5, 0, 32'h0), 1'b0);
    // r12 base needs sib
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_32, 5'd1, CLS_MEM, SZ_32, 5'd12, 8, 32'h0), 1'b0);
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_8, 5'd7, CLS_MEM, SZ_8, 5'd13, -128, 32'h0), 1'b0);
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_32, 5'd10, CLS_MEM, SZ_32, 5'd1, 128, 32'h0), 1'b0);
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_64, 5'd9, CLS_IMM, SZ_32, 5'd0, 0, 32'h8000_0001),
              1'b0);
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_8, 5'd12, CLS_IMM, SZ_8, 5'd0, 0, 32'h0000_00ff),
              1'b0);
    queue_req(mk_req(KIND_SUB, CLS_REG, SZ_8, 5'd0, CLS_IMM, SZ_8, 5'd0, 0, 32'h0000_007f),
              1'b0);
    queue_req(mk_req(KIND_SUB, CLS_REG, SZ_64, 5'd0, CLS_IMM, SZ_32, 5'd0, 0, 32'hdead_beef),
              1'b0);
    queue_req(mk_req(KIND_SUB, CLS_REG, SZ_16, 5'd3, CLS_IMM, SZ_8, 5'd0, 0, 32'h0000_0080),
              1'b0);
    queue_req(mk_req(KIND_SUB, CLS_MEM, SZ_64, 5'd13, CLS_IMM, SZ_32, 5'd0, 32'h8000_0000,
                     32'hffff_ffff), 1'b0);
    queue_req(mk_req(KIND_MOV, CLS_MEM, SZ_8, BASE_RIP, CLS_IMM, SZ_8, 5'd0, 0, 32'h0000_005a),
              1'b0);
    queue_req(mk_req(KIND_MOV, CLS_MEM, SZ_16, 5'd0, CLS_IMM, SZ_16, 5'd0, 0, 32'h0000_abcd),
              1'b0);
    // 64-bit immediate
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_64, 5'd0, CLS_IMM, SZ_64, 5'd0, 0, 32'h1), 1'b0);
    queue_req(mk_req(KIND_UNDEF, CLS_REG, SZ_64, 5'd0, CLS_REG, SZ_64, 5'd0, 0, 32'h0), 1'b0);
    // sub has no reg,mem form here
    queue_req(mk_req(KIND_SUB, CLS_REG, SZ_32, 5'd1, CLS_MEM, SZ_32, 5'd2, 0, 32'h0), 1'b0);
    queue_req(mk_req(KIND_MOV, CLS_REG, SZ_16, 5'd1, CLS_REG, SZ_32, 5'd2, 0, 32'h0), 1'b0);
    // base above rip
    queue_req(mk_req(KIND_MOV, CLS_MEM, SZ_32, 5'd17, CLS_IMM, SZ_32, 5'd0, 0, 32'h0), 1'b0);

    // random requests, mostly supported shapes
    for (i = 0; i < RANDOM_REQS; i++)
      queue_req(($urandom_range(0, 99) < 80) ? rand_wellformed() : rand_noise(),
                i == 0 || i == 150 || i == 300);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // all requests taken, then let the byte stream drain
    while (pending_reqs.size() != 0 || start) @(posedge clk);
    for (i = 0; i < 2000 && expected_codes.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_codes.size() != 0) begin
      fail_cnt++;
      $display("%0t: %0d expected bytes never arrived, next expected byte %h",
               $time, expected_codes.size(), expected_codes[0].val);
    end
    $display("encoded %0d requests (%0d unsupported forms), checked %0d result bytes",
             accepted_cnt, unsupported_cnt, checked_cnt);
    $display("%0d mismatches", fail_cnt);
    if (fail_cnt == 0) begin
      $display("x86_64_instruction_encoder_top_tb passed");
    end else begin
      $display("x86_64_instruction_encoder_top_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("x86_64_instruction_encoder_top_tb failed");
    $finish;
  end

endmodule
